// File: rtl/spims_pkg.sv
// ----------------------------------------------------------------------------
// spims_pkg
// Shared types and codes for the SPI master bit engine: action codes,
// configuration register indexes, the configuration bundle and the result.
// ----------------------------------------------------------------------------
package spims_pkg;

    // Action codes carried by each input word
    localparam int ACTION_W = 2;
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_IDLE  = 2'd2;

    // Fixed field widths
    localparam int TX_W        = 32;
    localparam int RX_W        = 32;
    localparam int COUNT_W     = 6;
    localparam int HALF_W      = 8;

    // Configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_POLARITY = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_PHASE    = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LSB_FIRST      = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD    = 4'd3;

    typedef struct packed {
        logic              clock_polarity;
        logic              clock_phase;
        logic              lsb_first;
        logic [HALF_W-1:0] half_period;
    } cfg_t;

    typedef struct packed {
        logic            sck;
        logic            mosi;
        logic            busy_res;
        logic            done_res;
        logic [RX_W-1:0] rx_word;
    } result_t;

endpackage

// File: rtl/spims_engine.sv
// ----------------------------------------------------------------------------
// spims_engine
// Bit engine state and the next-state logic for one tick. State advances on
// step; the result of the tick is presented combinationally on res.
// ----------------------------------------------------------------------------
module spims_engine #(
    parameter int WORD_BITS  = 32,
    parameter int DELAY_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  spims_pkg::cfg_t                     cfg,
    input  logic [spims_pkg::ACTION_W-1:0]      action,
    input  logic [spims_pkg::TX_W-1:0]          tx_word,
    input  logic [spims_pkg::COUNT_W-1:0]       bit_count,
    input  logic                                miso,
    output spims_pkg::result_t                  res
);

    localparam int CNT_W = $clog2(WORD_BITS + 1);
    localparam int POS_W = $clog2(WORD_BITS);
    localparam int CMP_W = CNT_W + spims_pkg::COUNT_W;

    logic [WORD_BITS-1:0]  tx_shift_reg, tx_shift_next;
    logic [WORD_BITS-1:0]  rx_shift_reg, rx_shift_next;
    logic [CNT_W-1:0]      bits_total_reg, bits_total_next;
    logic [CNT_W-1:0]      bit_index_reg, bit_index_next;
    logic                  in_sample_reg, in_sample_next;
    logic [DELAY_BITS-1:0] ticks_left_reg, ticks_left_next;
    logic                  active_reg, active_next;
    logic                  sck_reg, sck_next;
    logic                  mosi_reg, mosi_next;

    logic                  sample_level;
    logic [DELAY_BITS-1:0] phase_len;
    logic [DELAY_BITS+spims_pkg::HALF_W-1:0] half_ext;
    logic [WORD_BITS+spims_pkg::TX_W-1:0]    tx_ext;
    logic [WORD_BITS-1:0]  tx_load;
    logic [spims_pkg::RX_W+WORD_BITS-1:0]    rx_ext;
    logic [CMP_W-1:0]      count_ext;
    logic [CMP_W-1:0]      count_clamped;
    logic [CNT_W-1:0]      index_inc;
    logic                  do_setup;
    logic [WORD_BITS-1:0]  setup_tx;
    logic [CNT_W-1:0]      setup_total;
    logic [CNT_W-1:0]      setup_index;
    logic [CNT_W-1:0]      setup_pos;
    logic                  done;

    assign sample_level = (cfg.clock_polarity == cfg.clock_phase);
    assign half_ext     = {{DELAY_BITS{1'b0}}, cfg.half_period};
    assign phase_len    = half_ext[DELAY_BITS-1:0];
    assign tx_ext       = {{WORD_BITS{1'b0}}, tx_word};
    assign tx_load      = tx_ext[WORD_BITS-1:0];
    assign rx_ext       = {{spims_pkg::RX_W{1'b0}}, rx_shift_reg};
    assign count_ext    = {{CNT_W{1'b0}}, bit_count};
    assign index_inc    = bit_index_reg + CNT_W'(1);

    // Clamp the requested length into 1..WORD_BITS
    always_comb begin
        priority if (count_ext == '0) begin
            count_clamped = CMP_W'(1);
        end else if (count_ext > CMP_W'(WORD_BITS)) begin
            count_clamped = CMP_W'(WORD_BITS);
        end else begin
            count_clamped = count_ext;
        end
    end

    always_comb begin
        tx_shift_next   = tx_shift_reg;
        rx_shift_next   = rx_shift_reg;
        bits_total_next = bits_total_reg;
        bit_index_next  = bit_index_reg;
        in_sample_next  = in_sample_reg;
        ticks_left_next = ticks_left_reg;
        active_next     = active_reg;
        sck_next        = sck_reg;
        mosi_next       = mosi_reg;
        do_setup        = 1'b0;
        done            = 1'b0;
        setup_tx        = tx_shift_reg;
        setup_total     = bits_total_reg;
        setup_index     = index_inc;

        priority if (active_reg) begin
            priority if (ticks_left_reg != '0) begin
                ticks_left_next = ticks_left_reg - DELAY_BITS'(1);
            end else if (!in_sample_reg) begin
                // Sample phase: move SCK to the sample level, capture MISO
                sck_next        = sample_level;
                in_sample_next  = 1'b1;
                ticks_left_next = phase_len;
                if (cfg.lsb_first) begin
                    rx_shift_next[bit_index_reg[POS_W-1:0]] =
                        rx_shift_reg[bit_index_reg[POS_W-1:0]] | miso;
                end else begin
                    rx_shift_next = {rx_shift_reg[WORD_BITS-2:0], miso};
                end
            end else begin
                bit_index_next = index_inc;
                if (index_inc >= bits_total_reg) begin
                    active_next = 1'b0;
                    done        = 1'b1;
                end else begin
                    do_setup = 1'b1;
                end
            end
        end else if (action == spims_pkg::ACT_START) begin
            tx_shift_next   = tx_load;
            rx_shift_next   = '0;
            bits_total_next = count_clamped[CNT_W-1:0];
            bit_index_next  = '0;
            active_next     = 1'b1;
            do_setup        = 1'b1;
            setup_tx        = tx_load;
            setup_total     = count_clamped[CNT_W-1:0];
            setup_index     = '0;
        end else if (action == spims_pkg::ACT_IDLE) begin
            sck_next = cfg.clock_polarity;
        end else begin
            // Plain tick or unused code: hold everything
        end

        // Setup phase: drive SCK away from the sample level, put out next bit
        setup_pos = cfg.lsb_first ? setup_index
                                  : (setup_total - CNT_W'(1) - setup_index);
        if (do_setup) begin
            mosi_next       = setup_tx[setup_pos[POS_W-1:0]];
            sck_next        = ~sample_level;
            in_sample_next  = 1'b0;
            ticks_left_next = phase_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_shift_reg   <= '0;
            rx_shift_reg   <= '0;
            bits_total_reg <= '0;
            bit_index_reg  <= '0;
            in_sample_reg  <= 1'b0;
            ticks_left_reg <= '0;
            active_reg     <= 1'b0;
            sck_reg        <= 1'b0;
            mosi_reg       <= 1'b0;
        end else if (step) begin
            tx_shift_reg   <= tx_shift_next;
            rx_shift_reg   <= rx_shift_next;
            bits_total_reg <= bits_total_next;
            bit_index_reg  <= bit_index_next;
            in_sample_reg  <= in_sample_next;
            ticks_left_reg <= ticks_left_next;
            active_reg     <= active_next;
            sck_reg        <= sck_next;
            mosi_reg       <= mosi_next;
        end
    end

    assign res.sck      = sck_next;
    assign res.mosi     = mosi_next;
    assign res.busy_res = active_next;
    assign res.done_res = done;
    assign res.rx_word  = done ? rx_ext[spims_pkg::RX_W-1:0] : '0;

`ifndef SYNTHESIS
    a_index_below_total: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (bit_index_reg < bits_total_reg))
        else $error("bit index ran past transfer length");

    a_total_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (bits_total_reg != '0 && bits_total_reg <= CNT_W'(WORD_BITS)))
        else $error("transfer length out of range while active");

    a_done_ends_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && done) |=> (!active_reg && $past(active_reg)))
        else $error("done without ending an active transfer");

    a_hold_without_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> ($stable(active_reg) && $stable(bit_index_reg) && $stable(sck_reg)))
        else $error("engine state moved without a step");
`endif

endmodule

// File: rtl/spi_master_shifter.sv
// ----------------------------------------------------------------------------
// spi_master_shifter
// SPI master bit engine, modes 0 to 3, one input word per engine tick.
//
//   channel  direction  handshake              payload
//   s_       in         s_valid / s_ready      action, tx_word, bit_count, miso
//   m_       out        m_valid / m_ready      sck, mosi, busy_res, done_res,
//                                              rx_word
//   cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Accepts one word per cycle while m_ready is high; each word gives exactly
// one result word. A word passes through the input register, then the tick
// logic into the result register. Reset is synchronous on aresetn and needs
// no clearing pass. With m_ready low the result register holds, one more word
// waits in the input register, then s_ready drops. cfg_ready is always high.
// ----------------------------------------------------------------------------
module spi_master_shifter #(
    parameter int WORD_BITS  = 32,
    parameter int DELAY_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [spims_pkg::ACTION_W-1:0]      s_action,
    input  logic [spims_pkg::TX_W-1:0]          s_tx_word,
    input  logic [spims_pkg::COUNT_W-1:0]       s_bit_count,
    input  logic                                s_miso,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_sck,
    output logic                                m_mosi,
    output logic                                m_busy_res,
    output logic                                m_done_res,
    output logic [spims_pkg::RX_W-1:0]          m_rx_word,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [spims_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [spims_pkg::CFG_DATA_W-1:0]    cfg_data
);

    spims_pkg::cfg_t                        cfg_reg;

    logic                                   in_valid_reg;
    logic [spims_pkg::ACTION_W-1:0]         action_reg;
    logic [spims_pkg::TX_W-1:0]             tx_word_reg;
    logic [spims_pkg::COUNT_W-1:0]          bit_count_reg;
    logic                                   miso_reg;

    logic                                   out_valid_reg;
    spims_pkg::result_t                     res_reg;
    spims_pkg::result_t                     res_next;

    logic                                   advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                spims_pkg::CFG_CLOCK_POLARITY: cfg_reg.clock_polarity <= cfg_data[0];
                spims_pkg::CFG_CLOCK_PHASE:    cfg_reg.clock_phase    <= cfg_data[0];
                spims_pkg::CFG_LSB_FIRST:      cfg_reg.lsb_first      <= cfg_data[0];
                spims_pkg::CFG_HALF_PERIOD:    cfg_reg.half_period    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg    <= s_action;
            tx_word_reg   <= s_tx_word;
            bit_count_reg <= s_bit_count;
            miso_reg      <= s_miso;
        end
    end

    spims_engine #(
        .WORD_BITS  (WORD_BITS),
        .DELAY_BITS (DELAY_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .cfg       (cfg_reg),
        .action    (action_reg),
        .tx_word   (tx_word_reg),
        .bit_count (bit_count_reg),
        .miso      (miso_reg),
        .res       (res_next)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_sck      = res_reg.sck;
    assign m_mosi     = res_reg.mosi;
    assign m_busy_res = res_reg.busy_res;
    assign m_done_res = res_reg.done_res;
    assign m_rx_word  = res_reg.rx_word;

`ifndef SYNTHESIS
    a_input_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("waiting input word dropped");

    a_result_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(res_reg)))
        else $error("stalled result overwritten");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_reg.done_res) |-> !res_reg.busy_res)
        else $error("done reported with transfer still busy");
`endif

endmodule
